/* src/pctd_pkg.sv */
// Shared types and constants for the prefix-code table decoder.
package pctd_pkg;

    localparam int unsigned TABLE_DEPTH  = 256;
    localparam int unsigned MAX_CODE_LEN = 32;

    localparam int unsigned SYM_W        = 8;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned ENTRY_LEN_W  = 6;
    localparam int unsigned ENTRY_CODE_W = 32;
    localparam int unsigned ACTION_W     = 2;
    localparam int unsigned STATUS_W     = 2;

    localparam int unsigned ADDR_W     = $clog2(TABLE_DEPTH);
    localparam int unsigned COUNT_W    = $clog2(TABLE_DEPTH + 1);
    localparam int unsigned CUR_LEN_W  = $clog2(MAX_CODE_LEN + 1);
    localparam int unsigned LEN_W      = (ENTRY_LEN_W > CUR_LEN_W) ? ENTRY_LEN_W : CUR_LEN_W;
    localparam int unsigned CODE_W     = (ENTRY_CODE_W > MAX_CODE_LEN) ? ENTRY_CODE_W
                                                                       : MAX_CODE_LEN;
    localparam int unsigned BIT_CNT_W  = $clog2(BYTE_W + 1);

    // request actions
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DATA  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DECODED    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd2;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_SCAN,
        S_BIT_SHIFT,
        S_BIT_SCAN,
        S_FLUSH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture_load;
        logic capture_data;
        logic clear;
        logic scan_step;
        logic load_commit;
        logic shift_bit;
        logic resolve_bit;
        logic flush;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic bits_left;
    } dp_status_t;

endpackage

/* src/prefix_code_table_decoder.sv */
// Top level of the prefix-code table decoder: controller plus datapath.
//
// Usage: a request is taken when start is high and busy is low. action selects
// load entry, data byte or clear; the entry_* and data_byte ports carry its payload.
// Results come out on decoded_symbol / status / last_of_item, marked by
// result_valid for exactly one cycle; the receiver cannot stall, so
// every strobe must be captured. last_of_item flags the final result of a request.
// Steps (N = entries loaded, up to TABLE_DEPTH):
//   clear      : no result.
//   load entry : up to N table reads, one per cycle on the single memory read
//                port, then the commit. A full table gives one result with
//                status table full unless the key is already in the table.
//   data byte  : per bit a shift, then a scan of up to N entries; after the
//                last bit a flush. 0 to 8 results.
// Each result is held back one step so that last_of_item is known when it goes out.
// The table memory scan rate (one entry per cycle) sets the throughput.
// Reset empties the table (entry count zero) and the current code; the
// memory contents are not cleared, entries past the count are never read.
module prefix_code_table_decoder
    import pctd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [ACTION_W-1:0]     action,
    input  logic [SYM_W-1:0]        entry_symbol,
    input  logic [ENTRY_LEN_W-1:0]  entry_length,
    input  logic [ENTRY_CODE_W-1:0] entry_code,
    input  logic [BYTE_W-1:0]       data_byte,
    output logic                    result_valid,
    output logic [SYM_W-1:0]        decoded_symbol,
    output logic [STATUS_W-1:0]     status,
    output logic                    last_of_item
);

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // sequencer: one state per phase of a request
    pctd_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    // table, scan pipeline and result staging
    pctd_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .entry_symbol   (entry_symbol),
        .entry_length   (entry_length),
        .entry_code     (entry_code),
        .data_byte      (data_byte),
        .result_valid   (result_valid),
        .decoded_symbol (decoded_symbol),
        .status         (status),
        .last_of_item   (last_of_item)
    );

    // a failed decode or full table never carries a symbol
    a_no_symbol_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != ST_DECODED)) |-> (decoded_symbol == '0))
        else $error("symbol on non-decoded result");

    // a table-full result is always the only, hence last, result of its request
    a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == ST_TABLE_FULL)) |-> last_of_item)
        else $error("table full result not marked last");

    // a data byte request always keeps the block busy in the next cycle
    a_data_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_DATA)) |=> busy)
        else $error("data request not taken up");

    // the last result of a request leaves nothing pending: block already free while it shows
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last_of_item) |-> !busy)
        else $error("last result while still busy");

endmodule

/* src/pctd_datapath.sv */
// Datapath: code table memory, scan pipeline, current code and result registers.
module pctd_datapath
    import pctd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_cmd_t               cmd,
    output dp_status_t              sts,
    input  logic [SYM_W-1:0]        entry_symbol,
    input  logic [ENTRY_LEN_W-1:0]  entry_length,
    input  logic [ENTRY_CODE_W-1:0] entry_code,
    input  logic [BYTE_W-1:0]       data_byte,
    output logic                    result_valid,
    output logic [SYM_W-1:0]        decoded_symbol,
    output logic [STATUS_W-1:0]     status,
    output logic                    last_of_item
);

    // keep only the low len bits of a loaded code
    function automatic logic [ENTRY_CODE_W-1:0] mask_code(
        input logic [ENTRY_CODE_W-1:0] code,
        input logic [ENTRY_LEN_W-1:0]  len
    );
        logic [ENTRY_CODE_W-1:0] m;
        for (int i = 0; i < ENTRY_CODE_W; i++)
        begin
            m[i] = code[i] & (i < int'(len));
        end
        return m;
    endfunction

    entry_t mem [TABLE_DEPTH];

    entry_t                 rd_entry_reg;
    logic                   rd_en;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    entry_t                 mem_wdata;

    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [MAX_CODE_LEN-1:0] cur_code_reg, cur_code_next;
    logic [CUR_LEN_W-1:0]   cur_len_reg, cur_len_next;
    logic [COUNT_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [ADDR_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic                   res_valid_reg, res_valid_next;

    logic [LEN_W-1:0]       key_len_reg, key_len_next;
    logic [CODE_W-1:0]      key_code_reg, key_code_next;
    logic [SYM_W-1:0]       sym_reg, sym_next;
    logic [BYTE_W-1:0]      byte_reg, byte_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [SYM_W-1:0]       pend_sym_reg, pend_sym_next;
    logic [STATUS_W-1:0]    pend_status_reg, pend_status_next;
    logic [SYM_W-1:0]       res_sym_reg, res_sym_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic                   res_last_reg, res_last_next;

    logic                   match;
    logic                   scan_exhausted;
    logic                   table_full;
    logic                   at_max;
    logic [MAX_CODE_LEN-1:0] shifted_code;
    logic [CUR_LEN_W-1:0]   inc_len;

    assign match = cmp_valid_reg && (rd_entry_reg.len == key_len_reg)
                   && (rd_entry_reg.code == key_code_reg);
    assign scan_exhausted = (scan_idx_reg >= count_reg);
    assign table_full     = (count_reg == COUNT_W'(TABLE_DEPTH));
    assign at_max         = (cur_len_reg >= CUR_LEN_W'(MAX_CODE_LEN));
    assign shifted_code   = {cur_code_reg[MAX_CODE_LEN-2:0], byte_reg[BYTE_W-1]};
    assign inc_len        = cur_len_reg + 1'b1;

    assign sts.scan_done = match || (!cmp_valid_reg && scan_exhausted);
    assign sts.bits_left = (bit_cnt_reg != BIT_CNT_W'(BYTE_W));

    always_comb
    begin
        count_next       = count_reg;
        cur_code_next    = cur_code_reg;
        cur_len_next     = cur_len_reg;
        scan_idx_next    = scan_idx_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_idx_next     = cmp_idx_reg;
        pend_valid_next  = pend_valid_reg;
        res_valid_next   = 1'b0;
        key_len_next     = key_len_reg;
        key_code_next    = key_code_reg;
        sym_next         = sym_reg;
        byte_next        = byte_reg;
        bit_cnt_next     = bit_cnt_reg;
        pend_sym_next    = pend_sym_reg;
        pend_status_next = pend_status_reg;
        res_sym_next     = res_sym_reg;
        res_status_next  = res_status_reg;
        res_last_next    = res_last_reg;
        rd_en            = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = cmp_idx_reg;
        mem_wdata.sym    = sym_reg;
        mem_wdata.len    = key_len_reg;
        mem_wdata.code   = key_code_reg;

        if (cmd.capture_load)
        begin
            key_len_next   = LEN_W'(entry_length);
            key_code_next  = CODE_W'(mask_code(entry_code, entry_length));
            sym_next       = entry_symbol;
            scan_idx_next  = '0;
            cmp_valid_next = 1'b0;
        end

        if (cmd.capture_data)
        begin
            byte_next    = data_byte;
            bit_cnt_next = '0;
        end

        if (cmd.clear)
        begin
            count_next    = '0;
            cur_code_next = '0;
            cur_len_next  = '0;
        end

        // one table read issued per cycle, compared in the next cycle
        if (cmd.scan_step)
        begin
            rd_en          = !scan_exhausted;
            cmp_valid_next = !scan_exhausted;
            cmp_idx_next   = scan_idx_reg[ADDR_W-1:0];
            if (!scan_exhausted)
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
        end

        if (cmd.load_commit)
        begin
            priority if (match)
            begin
                // same key: only the symbol changes
                mem_we = 1'b1;
            end
            else if (!table_full)
            begin
                mem_we     = 1'b1;
                mem_waddr  = count_reg[ADDR_W-1:0];
                count_next = count_reg + 1'b1;
            end
            else
            begin
                res_valid_next  = 1'b1;
                res_sym_next    = '0;
                res_status_next = ST_TABLE_FULL;
                res_last_next   = 1'b1;
            end
        end

        if (cmd.shift_bit)
        begin
            cur_code_next  = shifted_code;
            cur_len_next   = inc_len;
            key_len_next   = LEN_W'(inc_len);
            key_code_next  = CODE_W'(shifted_code);
            byte_next      = {byte_reg[BYTE_W-2:0], 1'b0};
            bit_cnt_next   = bit_cnt_reg + 1'b1;
            scan_idx_next  = '0;
            cmp_valid_next = 1'b0;
        end

        // a new result pushes out the held one; the held one is sent last
        if (cmd.resolve_bit && (match || at_max))
        begin
            cur_code_next = '0;
            cur_len_next  = '0;
            if (pend_valid_reg)
            begin
                res_valid_next  = 1'b1;
                res_sym_next    = pend_sym_reg;
                res_status_next = pend_status_reg;
                res_last_next   = 1'b0;
            end
            pend_valid_next  = 1'b1;
            pend_sym_next    = match ? rd_entry_reg.sym : '0;
            pend_status_next = match ? ST_DECODED : ST_TOO_LONG;
        end

        if (cmd.flush)
        begin
            if (pend_valid_reg)
            begin
                res_valid_next  = 1'b1;
                res_sym_next    = pend_sym_reg;
                res_status_next = pend_status_reg;
                res_last_next   = 1'b1;
            end
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[scan_idx_reg[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            cur_code_reg   <= '0;
            cur_len_reg    <= '0;
            scan_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            cmp_idx_reg    <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            cur_code_reg   <= cur_code_next;
            cur_len_reg    <= cur_len_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_valid_reg  <= cmp_valid_next;
            cmp_idx_reg    <= cmp_idx_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_len_reg     <= key_len_next;
        key_code_reg    <= key_code_next;
        sym_reg         <= sym_next;
        byte_reg        <= byte_next;
        bit_cnt_reg     <= bit_cnt_next;
        pend_sym_reg    <= pend_sym_next;
        pend_status_reg <= pend_status_next;
        res_sym_reg     <= res_sym_next;
        res_status_reg  <= res_status_next;
        res_last_reg    <= res_last_next;
    end

    assign result_valid   = res_valid_reg;
    assign decoded_symbol = res_sym_reg;
    assign status         = res_status_reg;
    assign last_of_item   = res_last_reg;

endmodule

/* src/pctd_controller.sv */
// Controller: sequences request capture, table scans, bit shifts and result flush.
module pctd_controller
    import pctd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [ACTION_W-1:0] action,
    input  dp_status_t          sts,
    output ctrl_cmd_t           cmd,
    output logic                busy
);

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (action == ACT_LOAD)
                    begin
                        state_next = S_LOAD_SCAN;
                    end
                    else if (action == ACT_DATA)
                    begin
                        state_next = S_BIT_SHIFT;
                    end
                end
            end
            S_LOAD_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_BIT_SHIFT:
            begin
                state_next = S_BIT_SCAN;
            end
            S_BIT_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.bits_left ? S_BIT_SHIFT : S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture_load = (action == ACT_LOAD);
                    cmd.capture_data = (action == ACT_DATA);
                    cmd.clear        = (action == ACT_CLEAR);
                end
            end
            S_LOAD_SCAN:
            begin
                cmd.scan_step   = 1'b1;
                cmd.load_commit = sts.scan_done;
            end
            S_BIT_SHIFT:
            begin
                cmd.shift_bit = 1'b1;
            end
            S_BIT_SCAN:
            begin
                cmd.scan_step   = 1'b1;
                cmd.resolve_bit = sts.scan_done;
            end
            S_FLUSH:
            begin
                cmd.flush = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
